// ----- rtl/nearest_box_range_selector_defines.svh -----
// ----------------------------------------------------------------------------
// nearest_box_range_selector assertion macros
// Shared property wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_BOX_RANGE_SELECTOR_DEFINES_SVH
`define NEAREST_BOX_RANGE_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define NBRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nbrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbrs_pkg
// Word layouts, command codes and the gap function of the box range selector.
// ----------------------------------------------------------------------------
package nbrs_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 24;
    localparam int DIM_W     = 16;
    localparam int GAP_W     = 25;
    localparam int SEL_W     = 12;
    localparam int CNT_OUT_W = 13;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_RESET   = 3'd0;
    localparam t_cmd CMD_BEGIN   = 3'd1;
    localparam t_cmd CMD_LOAD    = 3'd2;
    localparam t_cmd CMD_END     = 3'd3;
    localparam t_cmd CMD_POINTER = 3'd4;
    localparam t_cmd CMD_SEL_ALL = 3'd5;
    localparam t_cmd CMD_CLEAR   = 3'd6;

    // input word, first field in the highest bits
    typedef struct packed {
        logic [5:0]              pad;
        logic                    held;
        logic                    press;
        logic [DIM_W-1:0]        box_height;
        logic [DIM_W-1:0]        box_width;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } t_in_word;

    // result word, first field in the highest bits
    typedef struct packed {
        logic                 dropped;
        logic [CNT_OUT_W-1:0] count_out;
        logic [SEL_W-1:0]     sel_hi;
        logic [SEL_W-1:0]     sel_lo;
        logic                 sel_valid;
        logic                 changed;
    } t_out_word;

    // one table entry
    typedef struct packed {
        logic [DIM_W-1:0]        h;
        logic [DIM_W-1:0]        w;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } t_box;

    typedef struct packed {
        logic we;
        t_box data;
    } t_box_wr;

    typedef struct packed {
        logic                    start;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
    } t_scan_req;

    // distance from p to the span [lo, lo+len], zero inside
    function automatic logic [GAP_W-1:0] f_gap(
        input logic signed [POS_W-1:0] p,
        input logic signed [POS_W-1:0] lo,
        input logic [DIM_W-1:0]        len
    );
        logic signed [GAP_W:0] d_lo;
        logic signed [GAP_W:0] hi;
        logic signed [GAP_W:0] d_hi;
        d_lo = (GAP_W+1)'(lo) - (GAP_W+1)'(p);
        hi   = (GAP_W+1)'(lo) + $signed({{(GAP_W+1-DIM_W){1'b0}}, len});
        d_hi = (GAP_W+1)'(p) - hi;
        if (!d_lo[GAP_W] && (d_lo != '0)) begin
            return d_lo[GAP_W-1:0];
        end else if (!d_hi[GAP_W] && (d_hi != '0)) begin
            return d_hi[GAP_W-1:0];
        end
        return '0;
    endfunction

endpackage

// ----- rtl/nbrs_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbrs_scan
// Box table memory and the nearest-box search: one entry read per cycle,
// gap stage, then a running best compare.
// ----------------------------------------------------------------------------
module nbrs_scan #(
    parameter int MAX_BOXES = 4096,
    parameter int IW        = $clog2(MAX_BOXES),
    parameter int CW        = $clog2(MAX_BOXES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nbrs_pkg::t_box_wr i_wr,
    input  logic [IW-1:0]     i_wr_addr,
    input  nbrs_pkg::t_scan_req i_req,
    input  logic [CW-1:0]     i_count,
    output logic              o_done,
    output logic [IW-1:0]     o_idx
);
    import nbrs_pkg::*;

    t_box r_mem [MAX_BOXES];
    t_box r_rd_data;

    logic                    r_busy;
    logic [CW-1:0]           r_addr_cnt;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic                    r_v1;
    logic [IW-1:0]           r_idx1;
    logic                    r_v2;
    logic [IW-1:0]           r_idx2;
    logic [GAP_W-1:0]        r_dy;
    logic [GAP_W-1:0]        r_dx;
    logic                    r_found;
    logic [GAP_W-1:0]        r_bdy;
    logic [GAP_W-1:0]        r_bdx;
    logic [IW-1:0]           r_best;
    logic                    r_done;

    logic w_issue;
    logic w_better;

    assign w_issue  = r_busy && (r_addr_cnt < i_count);
    assign w_better = !r_found || (r_dy < r_bdy) || ((r_dy == r_bdy) && (r_dx < r_bdx));

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[r_addr_cnt[IW-1:0]];
    end

    // gap and compare stages carry payload only
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_addr_cnt[IW-1:0];
        r_idx2 <= r_idx1;
        r_dy   <= f_gap(r_py, r_rd_data.y, r_rd_data.h);
        r_dx   <= f_gap(r_px, r_rd_data.x, r_rd_data.w);
        if (i_req.start && !r_busy) begin
            r_px <= i_req.px;
            r_py <= i_req.py;
        end
        if (r_v2 && w_better) begin
            r_bdy  <= r_dy;
            r_bdx  <= r_dx;
            r_best <= r_idx2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_addr_cnt <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_found    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_v1   <= w_issue;
            r_v2   <= r_v1;
            r_done <= 1'b0;
            if (w_issue) begin
                r_addr_cnt <= r_addr_cnt + 1'b1;
            end
            if (r_v2 && w_better) begin
                r_found <= 1'b1;
            end
            if (i_req.start && !r_busy) begin
                r_busy     <= 1'b1;
                r_addr_cnt <= '0;
                r_found    <= 1'b0;
            end else if (r_busy && !w_issue && !r_v1 && !r_v2) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_best;

endmodule

// ----- rtl/nearest_box_range_selector.sv -----
`timescale 1ns / 1ps
// Reset, reload, load, select-all, clear and pointer events that need no search
//   give their result word in the cycle after acceptance.
// A pointer press, or a held move while dragging, searches the table one box a
//   cycle through the single table read port.
// Throughput: one word at a time; the next word is taken once the result is out
//   or being taken. Synchronous active-low reset empties the table and drops the
//   selection, the anchor and the drag.
`include "nearest_box_range_selector_defines.svh"
// ----------------------------------------------------------------------------
// nearest_box_range_selector
// Word box table with selection range, drag anchor and nearest-box search.
// ----------------------------------------------------------------------------
module nearest_box_range_selector #(
    parameter int MAX_BOXES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // pos_x[23:0], pos_y[47:24], box_width[63:48], box_height[79:64],
    // press[80], held[81], zero pad[87:82]
    input  nbrs_pkg::t_in_word     i_s_axis_tdata,
    // cmd[2:0]
    input  nbrs_pkg::t_cmd         i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // changed[0], sel_valid[1], sel_lo[13:2], sel_hi[25:14], count_out[38:26],
    // dropped[39]
    output nbrs_pkg::t_out_word    o_m_axis_tdata
);
    import nbrs_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BOXES);

    // sequencer: idle, search running, search result waiting for the output
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_rv, n_rv;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic          r_av, n_av;
    logic [IW-1:0] r_aidx, n_aidx;
    logic          r_drag, n_drag;
    logic          r_press, n_press;
    logic [IW-1:0] r_near;
    logic          r_out_valid;
    t_out_word     r_out;

    logic          w_accept;
    logic          w_out_free;
    logic          w_load_out;
    logic          w_changed;
    logic          w_drop;
    logic          w_done;
    logic          w_full_load;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_min;
    logic [IW-1:0] w_max;
    logic [IW-1:0] w_clamp;
    t_box_wr       w_wr;
    t_scan_req     w_req;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // table append on a load that fits
    assign w_wr.we     = w_accept && (i_s_axis_tuser == CMD_LOAD) && (r_count < CNT_MAX);
    assign w_wr.data.x = i_s_axis_tdata.pos_x;
    assign w_wr.data.y = i_s_axis_tdata.pos_y;
    assign w_wr.data.w = i_s_axis_tdata.box_width;
    assign w_wr.data.h = i_s_axis_tdata.box_height;

    assign w_full_load = w_accept && (i_s_axis_tuser == CMD_LOAD) && (r_count == CNT_MAX);

    nbrs_scan #(
        .MAX_BOXES (MAX_BOXES)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_wr_addr (r_count[IW-1:0]),
        .i_req     (w_req),
        .i_count   (r_count),
        .o_done    (w_done),
        .o_idx     (w_idx)
    );

    // range ends from the found box and the anchor
    assign w_min   = (r_near < r_aidx) ? r_near : r_aidx;
    assign w_max   = (r_near < r_aidx) ? r_aidx : r_near;
    assign w_clamp = IW'(r_count - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rv        = r_rv;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_av        = r_av;
        n_aidx      = r_aidx;
        n_drag      = r_drag;
        n_press     = r_press;
        w_load_out  = 1'b0;
        w_changed   = 1'b0;
        w_drop      = 1'b0;
        w_req.start = 1'b0;
        w_req.px    = i_s_axis_tdata.pos_x;
        w_req.py    = i_s_axis_tdata.pos_y;

        if (w_accept) begin
            w_load_out = 1'b1;
            unique case (i_s_axis_tuser)
                CMD_RESET: begin
                    n_count = '0;
                    n_rv    = 1'b0;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_av    = 1'b0;
                    n_aidx  = '0;
                    n_drag  = 1'b0;
                end
                CMD_BEGIN: begin
                    n_count = '0;
                end
                CMD_LOAD: begin
                    if (r_count < CNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        w_drop = 1'b1;
                    end
                end
                CMD_END: begin
                    // clamp the range to the new table size
                    if (r_rv && (CW'(r_hi) >= r_count)) begin
                        if ((r_count == '0) || (r_lo > w_clamp)) begin
                            n_rv = 1'b0;
                            n_lo = '0;
                            n_hi = '0;
                        end else begin
                            n_hi = w_clamp;
                        end
                    end
                end
                CMD_POINTER: begin
                    n_press = i_s_axis_tdata.press;
                    if (i_s_axis_tdata.press) begin
                        if (r_count != '0) begin
                            w_req.start = 1'b1;
                            w_load_out  = 1'b0;
                            n_state     = ST_SCAN;
                        end else begin
                            n_av      = 1'b0;
                            n_aidx    = '0;
                            n_drag    = 1'b1;
                            w_changed = r_rv;
                            n_rv      = 1'b0;
                            n_lo      = '0;
                            n_hi      = '0;
                        end
                    end else if (!i_s_axis_tdata.held) begin
                        n_drag = 1'b0;
                    end else if (r_drag && r_av && (r_count != '0)) begin
                        w_req.start = 1'b1;
                        w_load_out  = 1'b0;
                        n_state     = ST_SCAN;
                    end
                end
                CMD_SEL_ALL: begin
                    if ((r_count != '0) &&
                        !(r_rv && (r_lo == '0) && (r_hi == w_clamp))) begin
                        n_rv      = 1'b1;
                        n_lo      = '0;
                        n_hi      = w_clamp;
                        w_changed = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    if (r_rv) begin
                        n_rv      = 1'b0;
                        n_lo      = '0;
                        n_hi      = '0;
                        w_changed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_SCAN: begin
                if (w_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_press) begin
                        // press: new anchor, selection dropped
                        n_av      = 1'b1;
                        n_aidx    = r_near;
                        n_drag    = 1'b1;
                        w_changed = r_rv;
                        n_rv      = 1'b0;
                        n_lo      = '0;
                        n_hi      = '0;
                    end else if (!(r_rv && (w_min == r_lo) && (w_max == r_hi))) begin
                        n_rv      = 1'b1;
                        n_lo      = w_min;
                        n_hi      = w_max;
                        w_changed = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_near <= w_idx;
        end
        if (w_load_out) begin
            r_out.changed   <= w_changed;
            r_out.sel_valid <= n_rv;
            r_out.sel_lo    <= n_rv ? SEL_W'(n_lo) : '0;
            r_out.sel_hi    <= n_rv ? SEL_W'(n_hi) : '0;
            r_out.count_out <= CNT_OUT_W'(n_count);
            r_out.dropped   <= w_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rv        <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_av        <= 1'b0;
            r_aidx      <= '0;
            r_drag      <= 1'b0;
            r_press     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_av    <= n_av;
            r_aidx  <= n_aidx;
            r_drag  <= n_drag;
            r_press <= n_press;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    `NBRS_ASSERT_NOW(a_range_order, r_rv, r_lo <= r_hi, "selection range out of order")
    `NBRS_ASSERT_NOW(a_done_in_scan, w_done, r_state == ST_SCAN, "search done outside a search")
    `NBRS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_MAX, "box count above table size")
    `NBRS_ASSERT_NEXT(a_full_drop, w_full_load, r_out_valid && r_out.dropped, "full load not flagged")

endmodule

// ----- tb/nearest_box_range_selector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_box_range_selector_tb
// Self-checking bench: streams command words into the box range selector,
// predicts each result word from its own copy of the box table and selection
// state, and compares every result field against that prediction.
// ----------------------------------------------------------------------------
module nearest_box_range_selector_tb;

    import nbrs_pkg::*;

    localparam int     TB_MAX     = 4096;
    localparam int     CLK_PERIOD = 20;
    localparam int     ROW_PITCH  = 256;        // 16.0 units per text line, Q.4
    localparam longint LIMIT_NS   = 20_000_000;

    typedef struct {
        t_cmd     cmd;
        t_in_word data;
        int       phase;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    t_in_word    s_tdata = '0;
    t_cmd        s_tuser = CMD_RESET;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    t_out_word   o_m_axis_tdata;

    nearest_box_range_selector #(
        .MAX_BOXES(TB_MAX)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #(CLK_PERIOD/2) i_clk = 1'b1;
        #(CLK_PERIOD/2) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted block state
    // ------------------------------------------------------------------
    int  box_x [TB_MAX];
    int  box_y [TB_MAX];
    int  box_w [TB_MAX];
    int  box_h [TB_MAX];
    int  word_count = 0;
    bit  range_on = 0;
    int  sel_first = 0;
    int  sel_last = 0;
    bit  anchor_on = 0;
    int  anchor_at = 0;
    bit  drag_on = 0;

    t_stim     words_to_send [$];
    t_out_word selection_due [$];

    int fail_count = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_changed = 0;
    int n_pointer = 0;
    int n_dropped = 0;
    int peak_count = 0;

    // distance from p to [lo, lo+len], zero inside
    function automatic longint span_gap(input longint p, input longint lo,
                                        input longint len);
        if (p < lo) return lo - p;
        if (p > lo + len) return p - (lo + len);
        return 0;
    endfunction

    // smallest vertical gap wins, then smallest horizontal; ties keep the earlier box
    function automatic bit find_nearest(input longint px, input longint py,
                                        output int idx);
        bit     found;
        longint bdy;
        longint bdx;
        longint dy;
        longint dx;
        found = 0;
        bdy = 0;
        bdx = 0;
        idx = 0;
        for (int i = 0; i < word_count; i++) begin
            dy = span_gap(py, box_y[i], box_h[i]);
            dx = span_gap(px, box_x[i], box_w[i]);
            if (!found || dy < bdy || (dy <= bdy && dx < bdx)) begin
                found = 1;
                idx = i;
                bdy = dy;
                bdx = dx;
            end
        end
        return found;
    endfunction

    function automatic t_out_word update_selection(input t_cmd cmd, input t_in_word w);
        t_out_word r;
        bit        chg;
        bit        drop;
        bit        found;
        int        hit;
        int        lo;
        int        hi;
        longint    px;
        longint    py;
        chg = 0;
        drop = 0;
        px = $signed(w.pos_x);
        py = $signed(w.pos_y);
        case (cmd)
            CMD_RESET: begin
                word_count = 0;
                range_on = 0;
                sel_first = 0;
                sel_last = 0;
                anchor_on = 0;
                anchor_at = 0;
                drag_on = 0;
            end
            CMD_BEGIN: begin
                word_count = 0;
            end
            CMD_LOAD: begin
                if (word_count < TB_MAX) begin
                    box_x[word_count] = int'(px);
                    box_y[word_count] = int'(py);
                    box_w[word_count] = int'(w.box_width);
                    box_h[word_count] = int'(w.box_height);
                    word_count++;
                end else begin
                    drop = 1;
                end
            end
            CMD_END: begin
                // clamp the range to the new count; anchor is left alone
                if (range_on && sel_last >= word_count) begin
                    if (word_count == 0 || sel_first > word_count - 1) begin
                        range_on = 0;
                        sel_first = 0;
                        sel_last = 0;
                    end else begin
                        sel_last = word_count - 1;
                    end
                end
            end
            CMD_POINTER: begin
                n_pointer++;
                if (w.press) begin
                    anchor_on = find_nearest(px, py, hit);
                    anchor_at = anchor_on ? hit : 0;
                    drag_on = 1;
                    chg = range_on;
                    range_on = 0;
                    sel_first = 0;
                    sel_last = 0;
                end else if (!w.held) begin
                    drag_on = 0;
                end else if (drag_on && anchor_on) begin
                    found = find_nearest(px, py, hit);
                    if (found) begin
                        lo = (hit < anchor_at) ? hit : anchor_at;
                        hi = (hit < anchor_at) ? anchor_at : hit;
                        if (!(range_on && lo == sel_first && hi == sel_last)) begin
                            range_on = 1;
                            sel_first = lo;
                            sel_last = hi;
                            chg = 1;
                        end
                    end
                end
            end
            CMD_SEL_ALL: begin
                if (word_count > 0 &&
                    !(range_on && sel_first == 0 && sel_last == word_count - 1)) begin
                    range_on = 1;
                    sel_first = 0;
                    sel_last = word_count - 1;
                    chg = 1;
                end
            end
            CMD_CLEAR: begin
                if (range_on) begin
                    range_on = 0;
                    sel_first = 0;
                    sel_last = 0;
                    chg = 1;
                end
            end
            default: begin
            end
        endcase
        if (drop) n_dropped++;
        if (word_count > peak_count) peak_count = word_count;
        r = '0;
        r.changed   = chg;
        r.sel_valid = range_on;
        r.sel_lo    = range_on ? SEL_W'(sel_first) : '0;
        r.sel_hi    = range_on ? SEL_W'(sel_last) : '0;
        r.count_out = CNT_OUT_W'(word_count);
        r.dropped   = drop;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stall pattern per phase: 0 light sender / heavy receiver gaps,
    // 1 the other way round, 2 none
    // ------------------------------------------------------------------
    function automatic bit stall_now(input int ph, input bit sender);
        int pct;
        if (ph == 0) pct = sender ? 9 : 81;
        else if (ph == 1) pct = sender ? 81 : 9;
        else pct = 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    t_stim cur_word;
    int    active_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_RESET;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                selection_due.push_back(update_selection(cur_word.cmd, cur_word.data));
                n_sent++;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (words_to_send.size() > 0 && !stall_now(words_to_send[0].phase, 1'b1)) begin
                    cur_word = words_to_send.pop_front();
                    active_phase = cur_word.phase;
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_word.data;
                    s_tuser  <= cur_word.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= {6'd0, 82'({$urandom, $urandom, $urandom})};
                    s_tuser  <= t_cmd'($urandom_range(0, 7));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    t_out_word want_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (selection_due.size() == 0) begin
                    $error("result word with nothing outstanding: %h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want_word = selection_due.pop_front();
                    check_field("changed", want_word.changed, o_m_axis_tdata.changed);
                    check_field("sel_valid", want_word.sel_valid, o_m_axis_tdata.sel_valid);
                    check_field("sel_lo", want_word.sel_lo, o_m_axis_tdata.sel_lo);
                    check_field("sel_hi", want_word.sel_hi, o_m_axis_tdata.sel_hi);
                    check_field("count_out", want_word.count_out, o_m_axis_tdata.count_out);
                    check_field("dropped", want_word.dropped, o_m_axis_tdata.dropped);
                    if (want_word.changed) n_changed++;
                    n_checked++;
                end
            end
            m_tready <= !stall_now(active_phase, 1'b0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    int gen_phase = 0;
    int gen_count = 0;
    int lay_x0 = 0;
    int lay_y0 = 0;
    int lay_cx = 0;
    int lay_cy = 0;
    int last_x = 0;
    int last_y = 0;
    int last_w = 0;
    int last_h = 0;

    task automatic push_word(input t_cmd cmd, input int x, input int y, input int w,
                             input int h, input bit press, input bit held);
        t_stim s;
        s.cmd = cmd;
        s.data = '0;
        s.data.pos_x = POS_W'(x);
        s.data.pos_y = POS_W'(y);
        s.data.box_width = DIM_W'(w);
        s.data.box_height = DIM_W'(h);
        s.data.press = press;
        s.data.held = held;
        s.phase = gen_phase;
        words_to_send.push_back(s);
        gen_count++;
    endtask

    task automatic start_layout();
        lay_x0 = $urandom_range(0, 4000);
        lay_x0 -= 2000;
        lay_y0 = $urandom_range(0, 4000);
        lay_y0 -= 2000;
        lay_cx = lay_x0;
        lay_cy = lay_y0;
    endtask

    // one load: mostly words flowing along text lines, some wild, some exact repeats
    task automatic push_box();
        int roll;
        int w;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            w = $urandom_range(16, 1200);
            if (lay_cx + w > lay_x0 + 8000) begin
                lay_cx = lay_x0;
                lay_cy += ROW_PITCH;
            end
            last_x = lay_cx;
            last_y = lay_cy;
            last_w = w;
            last_h = ($urandom_range(0, 1) == 0) ? 192 : $urandom_range(64, 256);
            lay_cx += w + $urandom_range(0, 96);
        end else if (roll < 90) begin
            last_x = $urandom;
            last_y = $urandom;
            last_w = $urandom_range(0, 65535);
            last_h = $urandom_range(0, 65535);
        end
        push_word(CMD_LOAD, last_x, last_y, last_w, last_h, 1'b0, 1'b0);
    endtask

    task automatic push_pointer(input bit press, input bit held);
        int px;
        int py;
        if ($urandom_range(0, 3) != 0) begin
            px = lay_x0 - 400 + $urandom_range(0, 9000);
            py = lay_y0 - 300 + $urandom_range(0, lay_cy - lay_y0 + 600);
        end else begin
            px = $urandom;
            py = $urandom;
        end
        push_word(CMD_POINTER, px, py, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  press, held);
    endtask

    // mostly well-formed reload and drag sequences, the rest noise
    task automatic run_random(input int upto);
        int roll;
        int k;
        while (gen_count < upto) begin
            roll = $urandom_range(0, 99);
            if (roll < 28) begin
                start_layout();
                if ($urandom_range(0, 9) != 0) push_word(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
                k = $urandom_range(0, 12);
                repeat (k) push_box();
                if ($urandom_range(0, 9) != 0) push_word(CMD_END, 0, 0, 0, 0, 0, 0);
            end else if (roll < 65) begin
                push_pointer(1'b1, $urandom_range(0, 1));
                k = $urandom_range(0, 5);
                repeat (k) push_pointer(1'b0, 1'b1);
                if ($urandom_range(0, 4) != 0) push_pointer(1'b0, 1'b0);
            end else if (roll < 75) begin
                push_word(CMD_SEL_ALL, $urandom, $urandom, 0, 0, 0, 0);
            end else if (roll < 83) begin
                push_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
            end else if (roll < 87) begin
                push_word(CMD_RESET, 0, 0, 0, 0, 0, 0);
            end else begin
                push_word(t_cmd'($urandom_range(0, 7)), $urandom, $urandom,
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        gen_phase = 0;
        // empty table: press gets no anchor, held move and select-all do nothing
        push_word(CMD_POINTER, 0, 0, 0, 0, 1'b1, 1'b0);
        push_word(CMD_POINTER, 0, 0, 0, 0, 1'b0, 1'b1);
        push_word(CMD_SEL_ALL, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0);
        // unused code with every field bit set
        push_word(t_cmd'(7), -1, -1, 65535, 65535, 1'b1, 1'b1);
        // field extremes, a same-row pair and an exact duplicate
        push_word(CMD_LOAD, -8388608, -8388608, 65535, 65535, 1'b0, 1'b0);
        push_word(CMD_LOAD, 8388607, 8388607, 0, 0, 1'b0, 1'b0);
        push_word(CMD_LOAD, 0, 0, 160, 160, 1'b0, 1'b0);
        push_word(CMD_LOAD, 320, 0, 160, 160, 1'b0, 1'b0);
        push_word(CMD_LOAD, 0, 0, 160, 160, 1'b0, 1'b0);
        // equal vertical gaps: horizontal gap picks box 3
        push_word(CMD_POINTER, 400, 80, 0, 0, 1'b1, 1'b0);
        push_word(CMD_POINTER, -8388608, -8388608, 0, 0, 1'b0, 1'b1);
        push_word(CMD_POINTER, -8388608, -8388608, 0, 0, 1'b0, 1'b1);
        push_word(CMD_POINTER, 8388607, 8388607, 0, 0, 1'b0, 1'b1);
        push_word(CMD_POINTER, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_POINTER, 0, 0, 0, 0, 1'b0, 1'b1);
        push_word(CMD_SEL_ALL, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_SEL_ALL, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0);
        // full tie with the duplicate keeps the earlier box
        push_word(CMD_POINTER, 80, 80, 0, 0, 1'b1, 1'b1);
        push_word(CMD_POINTER, 400, 80, 0, 0, 1'b0, 1'b1);
        // shrink under the range so it empties, then drag from the stale anchor
        push_word(CMD_BEGIN, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_LOAD, 0, 0, 160, 160, 1'b0, 1'b0);
        push_word(CMD_END, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_POINTER, 0, 0, 0, 0, 1'b0, 1'b1);
        push_word(CMD_RESET, 0, 0, 0, 0, 1'b0, 1'b0);

        start_layout();
        run_random(gen_count + 30);
        gen_phase = 1;
        run_random(gen_count + 30);
        gen_phase = 2;
        run_random(gen_count + 30);

        // load a page, search it, then reload below the range
        push_word(CMD_RESET, 0, 0, 0, 0, 1'b0, 1'b0);
        start_layout();
        repeat (12) push_box();
        push_pointer(1'b1, 1'b0);
        push_pointer(1'b0, 1'b1);
        push_word(CMD_SEL_ALL, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_END, 0, 0, 0, 0, 1'b0, 1'b0);
        push_word(CMD_BEGIN, 0, 0, 0, 0, 1'b0, 1'b0);
        start_layout();
        repeat (3) push_box();
        push_word(CMD_END, 0, 0, 0, 0, 1'b0, 1'b0);
        push_pointer(1'b0, 1'b1);
        push_pointer(1'b0, 1'b0);
        push_word(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || s_tvalid || selection_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d words (%0d pointer events), checked %0d results, %0d changed",
                 n_sent, n_pointer, n_checked, n_changed);
        $display("Table peaked at %0d boxes, %0d loads dropped while full",
                 peak_count, n_dropped);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
